### rtl/gsf_pkg.sv
// ----------------------------------------------------------------------------
// gsf_pkg: shared types and constants of the gzip stored-stream framer
// Holds the descriptor handed from the item processor to the byte emitter,
// the stored-block size limit and the CRC-32 constants.
// ----------------------------------------------------------------------------
package gsf_pkg;

    // Largest LEN of one stored DEFLATE block
    localparam logic [15:0] MAX_BLOCK = 16'd65535;

    // Reflected CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // gzip header constants
    localparam logic [7:0] GZ_ID1 = 8'h1F;
    localparam logic [7:0] GZ_ID2 = 8'h8B;
    localparam logic [7:0] GZ_CM  = 8'h08;

    localparam logic [7:0] OS_CODE_RESET = 8'h03;

    // Everything the emitter needs to play out the bytes of one request
    typedef struct packed {
        logic        has_hdr;    // 10-byte gzip header
        logic        has_blk;    // 5-byte stored block header
        logic        has_data;   // one data byte (also the stray-byte slot)
        logic        has_ftr;    // CRC and ISIZE
        logic        err;        // stray data byte
        logic        blk_final;
        logic [15:0] blk_len;
        logic [7:0]  data;
        logic [7:0]  os;
        logic [31:0] crc_out;
        logic [31:0] isize;
    } gsf_desc_t;

endpackage

### rtl/gsf_proc.sv
// ----------------------------------------------------------------------------
// gsf_proc: stream state and per-request decode
// Keeps CRC, byte and block counters and the OS code register; turns one
// request into an emit descriptor and updates state when it is loaded.
// ----------------------------------------------------------------------------
module gsf_proc
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                load,
    input  logic                item_func,
    input  logic [7:0]          item_data,
    input  logic [31:0]         item_len,
    output gsf_pkg::gsf_desc_t  desc
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [15:0] block_left_reg, block_left_next;
    logic [31:0] total_length_reg, total_length_next;
    logic        open_reg, open_next;
    logic [7:0]  os_code_reg;

    logic [31:0] crc_upd;
    logic [15:0] blk_len;
    logic [15:0] blk_cur;
    logic [31:0] left_dec;
    logic        fits;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (gsf_pkg::CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    assign crc_upd  = crc_byte(crc_reg, item_data);
    assign fits     = (bytes_left_reg <= {16'd0, gsf_pkg::MAX_BLOCK});
    assign blk_len  = fits ? bytes_left_reg[15:0] : gsf_pkg::MAX_BLOCK;
    assign blk_cur  = (block_left_reg == 16'd0) ? blk_len : block_left_reg;
    assign left_dec = bytes_left_reg - 32'd1;

    always_comb
    begin
        crc_next          = crc_reg;
        bytes_left_next   = bytes_left_reg;
        block_left_next   = block_left_reg;
        total_length_next = total_length_reg;
        open_next         = open_reg;

        desc           = '0;
        desc.os        = os_code_reg;
        desc.isize     = total_length_reg;
        desc.data      = item_data;

        if (!item_func)
        begin
            // start: header, and for an empty stream a final empty block plus footer
            crc_next          = gsf_pkg::CRC_INIT;
            total_length_next = item_len;
            bytes_left_next   = item_len;
            block_left_next   = 16'd0;
            open_next         = (item_len != 32'd0);
            desc.has_hdr      = 1'b1;
            desc.has_blk      = (item_len == 32'd0);
            desc.has_ftr      = (item_len == 32'd0);
            desc.blk_final    = 1'b1;
            desc.blk_len      = 16'd0;
            desc.crc_out      = 32'd0;
            desc.isize        = 32'd0;
        end
        else if (!open_reg || bytes_left_reg == 32'd0)
        begin
            // stray byte: one zero byte flagged as error, state untouched
            desc.has_data = 1'b1;
            desc.err      = 1'b1;
            desc.data     = 8'h00;
        end
        else
        begin
            desc.has_data   = 1'b1;
            desc.has_blk    = (block_left_reg == 16'd0);
            desc.blk_final  = fits;
            desc.blk_len    = blk_len;
            desc.crc_out    = crc_upd ^ gsf_pkg::CRC_INIT;
            desc.has_ftr    = (left_dec == 32'd0);
            crc_next        = crc_upd;
            bytes_left_next = left_dec;
            block_left_next = blk_cur - 16'd1;
            if (left_dec == 32'd0)
            begin
                open_next       = 1'b0;
                block_left_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg          <= gsf_pkg::CRC_INIT;
            bytes_left_reg   <= 32'd0;
            block_left_reg   <= 16'd0;
            total_length_reg <= 32'd0;
            open_reg         <= 1'b0;
            os_code_reg      <= gsf_pkg::OS_CODE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                os_code_reg <= cfg_wdata;
            end
            if (load)
            begin
                crc_reg          <= crc_next;
                bytes_left_reg   <= bytes_left_next;
                block_left_reg   <= block_left_next;
                total_length_reg <= total_length_next;
                open_reg         <= open_next;
            end
        end
    end

endmodule

### rtl/gsf_emit.sv
// ----------------------------------------------------------------------------
// gsf_emit: byte sequencer and output register
// Walks the slots of one descriptor (header, block header, data, footer),
// skipping absent sections, one byte per accepted output cycle.
// ----------------------------------------------------------------------------
module gsf_emit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  gsf_pkg::gsf_desc_t  desc_in,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);

    localparam logic [4:0] POS_ID1    = 5'd0;
    localparam logic [4:0] POS_ID2    = 5'd1;
    localparam logic [4:0] POS_CM     = 5'd2;
    localparam logic [4:0] POS_FLG    = 5'd3;
    localparam logic [4:0] POS_MT0    = 5'd4;
    localparam logic [4:0] POS_MT1    = 5'd5;
    localparam logic [4:0] POS_MT2    = 5'd6;
    localparam logic [4:0] POS_MT3    = 5'd7;
    localparam logic [4:0] POS_XFL    = 5'd8;
    localparam logic [4:0] POS_OS     = 5'd9;
    localparam logic [4:0] POS_BFLAG  = 5'd10;
    localparam logic [4:0] POS_LEN0   = 5'd11;
    localparam logic [4:0] POS_LEN1   = 5'd12;
    localparam logic [4:0] POS_NLEN0  = 5'd13;
    localparam logic [4:0] POS_NLEN1  = 5'd14;
    localparam logic [4:0] POS_DATA   = 5'd15;
    localparam logic [4:0] POS_CRC0   = 5'd16;
    localparam logic [4:0] POS_CRC1   = 5'd17;
    localparam logic [4:0] POS_CRC2   = 5'd18;
    localparam logic [4:0] POS_CRC3   = 5'd19;
    localparam logic [4:0] POS_ISZ0   = 5'd20;
    localparam logic [4:0] POS_ISZ1   = 5'd21;
    localparam logic [4:0] POS_ISZ2   = 5'd22;
    localparam logic [4:0] POS_ISZ3   = 5'd23;

    gsf_pkg::gsf_desc_t desc_reg;
    logic [4:0]  pos_reg, pos_next;
    logic        busy_reg, busy_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_end_reg;
    logic        out_err_reg;

    logic        out_load;
    logic        more;
    logic [4:0]  step_pos;
    logic [7:0]  byte_sel;
    logic [15:0] nlen;

    function automatic logic [4:0] first_pos(input gsf_pkg::gsf_desc_t d);
        priority if (d.has_hdr)      return POS_ID1;
        else if (d.has_blk)          return POS_BFLAG;
        else                         return POS_DATA;
    endfunction

    // {more, next slot} after the current slot
    always_comb
    begin
        more     = 1'b1;
        step_pos = pos_reg + 5'd1;
        priority if (pos_reg == POS_OS)
        begin
            priority if (desc_reg.has_blk)       step_pos = POS_BFLAG;
            else if (desc_reg.has_data)          step_pos = POS_DATA;
            else if (desc_reg.has_ftr)           step_pos = POS_CRC0;
            else                                 more     = 1'b0;
        end
        else if (pos_reg == POS_NLEN1)
        begin
            priority if (desc_reg.has_data)      step_pos = POS_DATA;
            else if (desc_reg.has_ftr)           step_pos = POS_CRC0;
            else                                 more     = 1'b0;
        end
        else if (pos_reg == POS_DATA)
        begin
            if (desc_reg.has_ftr)
            begin
                step_pos = POS_CRC0;
            end
            else
            begin
                more = 1'b0;
            end
        end
        else if (pos_reg == POS_ISZ3)
        begin
            more = 1'b0;
        end
        else
        begin
            more = 1'b1;
        end
    end

    assign nlen = ~desc_reg.blk_len;

    always_comb
    begin
        unique case (pos_reg)
            POS_ID1:   byte_sel = gsf_pkg::GZ_ID1;
            POS_ID2:   byte_sel = gsf_pkg::GZ_ID2;
            POS_CM:    byte_sel = gsf_pkg::GZ_CM;
            POS_FLG, POS_MT0, POS_MT1, POS_MT2, POS_MT3, POS_XFL:
                       byte_sel = 8'h00;
            POS_OS:    byte_sel = desc_reg.os;
            POS_BFLAG: byte_sel = {7'd0, desc_reg.blk_final};
            POS_LEN0:  byte_sel = desc_reg.blk_len[7:0];
            POS_LEN1:  byte_sel = desc_reg.blk_len[15:8];
            POS_NLEN0: byte_sel = nlen[7:0];
            POS_NLEN1: byte_sel = nlen[15:8];
            POS_DATA:  byte_sel = desc_reg.data;
            POS_CRC0:  byte_sel = desc_reg.crc_out[7:0];
            POS_CRC1:  byte_sel = desc_reg.crc_out[15:8];
            POS_CRC2:  byte_sel = desc_reg.crc_out[23:16];
            POS_CRC3:  byte_sel = desc_reg.crc_out[31:24];
            POS_ISZ0:  byte_sel = desc_reg.isize[7:0];
            POS_ISZ1:  byte_sel = desc_reg.isize[15:8];
            POS_ISZ2:  byte_sel = desc_reg.isize[23:16];
            POS_ISZ3:  byte_sel = desc_reg.isize[31:24];
            default:   byte_sel = 8'h00;
        endcase
    end

    assign out_load = busy_reg && (!out_valid_reg || m_tready);
    assign free     = !busy_reg || (out_load && !more);

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = first_pos(desc_in);
        end
        else if (out_load)
        begin
            busy_next = more;
            pos_next  = step_pos;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_ID1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc_in;
        end
        if (out_load)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= !more;
            out_end_reg  <= (pos_reg == POS_ISZ3);
            out_err_reg  <= desc_reg.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_err_reg, out_end_reg};

endmodule

### rtl/gzip_stored_stream_framer_core.sv
// ----------------------------------------------------------------------------
// gzip_stored_stream_framer_core: gzip framer over stored DEFLATE blocks
// Wraps a stream of raw bytes as a gzip file with CRC-32 and ISIZE footer.
// ----------------------------------------------------------------------------
// Path: a request passes the input register, then the descriptor register,
//   then the output register before its first byte appears on m_tdata.
// Throughput: one byte per cycle while m_tready is high; a request holds the
//   emitter until all its bytes are out: 1 for a plain data byte, 6 at a block
//   start, 9 or 14 at stream end, 10 for a start, 23 for an empty stream.
// Reset (rst_n low, asynchronous): all channels empty, no stream open, CRC at
//   all ones, OS code 3.
// ----------------------------------------------------------------------------
module gzip_stored_stream_framer_core
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration: OS code byte of the gzip header
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [7:0] data_byte, [39:8] stream_length
    input  logic        s_tuser,    // [0] func: 0 start of stream, 1 data byte

    // gzip byte channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // last byte caused by one request
    output logic [1:0]  m_tuser     // [0] stream_end, [1] error
);

    // Input register: hold one request until the emitter can take its bytes
    logic        item_valid_reg, item_valid_next;
    logic        item_func_reg;
    logic [7:0]  item_data_reg;
    logic [31:0] item_len_reg;

    logic               emit_free;
    logic               desc_load;
    gsf_pkg::gsf_desc_t desc;

    // Load the held request into the emitter once it is idle or the previous
    // request's last byte enters the output register; state advances on the same edge.
    assign desc_load = item_valid_reg && emit_free;
    assign s_tready  = !item_valid_reg || desc_load;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (s_tvalid && s_tready)
        begin
            item_valid_next = 1'b1;
        end
        else if (desc_load)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_func_reg <= s_tuser;
            item_data_reg <= s_tdata[7:0];
            item_len_reg  <= s_tdata[39:8];
        end
    end

    // Decode the request against stream state (CRC, counters, OS code)
    gsf_proc u_proc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .load      (desc_load),
        .item_func (item_func_reg),
        .item_data (item_data_reg),
        .item_len  (item_len_reg),
        .desc      (desc)
    );

    // Play out header, block header, data and footer bytes
    gsf_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (desc_load),
        .desc_in  (desc),
        .free     (emit_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/gsf_checker.sv
// ----------------------------------------------------------------------------
// gsf_checker: port-level checks of the gzip stored-stream framer
// Watches the output channel for stalls and for the marking of error and
// stream-end bytes.
// ----------------------------------------------------------------------------
module gsf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser
);

    // a stalled byte holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output byte changed while stalled");

    // a stray-byte response is a lone zero byte that ends its request
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 8'h00 && !m_tuser[0])
        else $error("malformed error response");

    // the stream's last byte also closes the request that caused it
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("stream end without request end");

endmodule

bind gzip_stored_stream_framer_core gsf_checker u_gsf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
